>>> rtl/riv_allocation_codec_core_assert.svh
`ifndef RIV_ALLOCATION_CODEC_CORE_ASSERT_SVH
`define RIV_ALLOCATION_CODEC_CORE_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define RIVAC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rivac check failed");

// condition must hold after the trigger, at the delay given by dly
`define RIVAC_ASSERT_LATER(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
      else $error("rivac latency check failed");

`endif

>>> rtl/rivac_pkg.sv
`timescale 1ns / 1ps

package rivac_pkg;

   // field widths
   localparam int RIV_IN_W   = 13;
   localparam int NPRB_W     = 7;
   localparam int RIV_OUT_W  = 14;
   localparam int DEC_W      = 8;
   localparam int CSR_IDX_W  = 1;

   // register reset values
   localparam logic [NPRB_W-1:0] NUM_PRB_RESET = 7'd100;
   localparam logic [NPRB_W-1:0] NUM_VRB_RESET = 7'd100;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_PRB = 1'b0,
      CSR_NUM_VRB = 1'b1
   } csr_index_type;

   typedef enum logic {
      MODE_ENCODE = 1'b0,
      MODE_DECODE = 1'b1
   } mode_type;

   // classified work item as queued
   typedef struct packed {
      mode_type                mode;
      logic [RIV_OUT_W-1:0]    factor;
      logic [RIV_OUT_W-1:0]    addend;
      logic [RIV_IN_W-1:0]     riv;
   } item_type;

   // one stage of the back pipeline
   typedef struct packed {
      mode_type                mode;
      logic [RIV_OUT_W-1:0]    prod;
      logic [RIV_OUT_W-1:0]    addend;
      logic [RIV_IN_W-1:0]     riv;
      logic [RIV_IN_W-1:0]     quo;
      logic [NPRB_W-1:0]       rem;
   } stage_type;

   typedef struct packed {
      logic full;
      logic nonempty;
   } q_status_type;

   typedef struct packed {
      logic [RIV_OUT_W-1:0] riv_out;
      logic [DEC_W-1:0]     length_out;
      logic [DEC_W-1:0]     start_out;
   } rsp_type;

endpackage

>>> rtl/riv_allocation_codec_core.sv
// an accepted start reaches rsp_valid through the queue, stage 0, the divider stages and the
// output register; the divider resolves one quotient bit per stage
// throughput: one beat per cycle; busy rises only if the front queue fills
// results are strobed for one cycle on rsp_valid and cannot be held off
// reset (synchronous, active high) empties the queue and pipeline and sets
// num_prb and num_vrb to 100
`timescale 1ns / 1ps

module riv_allocation_codec_core #(
   parameter int RIV_WIDTH = 13
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_mode,
   input  logic [rivac_pkg::NPRB_W-1:0]      req_length_rbs,
   input  logic [rivac_pkg::NPRB_W-1:0]      req_start_rb,
   input  logic [rivac_pkg::RIV_IN_W-1:0]    req_riv_in,
   output logic                              rsp_valid,
   output logic [rivac_pkg::RIV_OUT_W-1:0]   rsp_riv_out,
   output logic [rivac_pkg::DEC_W-1:0]       rsp_length_out,
   output logic [rivac_pkg::DEC_W-1:0]       rsp_start_out,
   input  logic                              csr_we,
   input  logic [rivac_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rivac_pkg::NPRB_W-1:0]      csr_wdata
);

   logic [rivac_pkg::NPRB_W-1:0] num_prb_ff;
   logic [rivac_pkg::NPRB_W-1:0] num_vrb_ff;
   rivac_pkg::item_type          front_item;
   rivac_pkg::item_type          head_item;
   rivac_pkg::q_status_type      q_status;
   rivac_pkg::rsp_type           rsp;
   logic                         push;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_prb_ff <= rivac_pkg::NUM_PRB_RESET;
         num_vrb_ff <= rivac_pkg::NUM_VRB_RESET;
      end else if (csr_we) begin
         unique case (rivac_pkg::csr_index_type'(csr_index))
            rivac_pkg::CSR_NUM_PRB: num_prb_ff <= csr_wdata;
            rivac_pkg::CSR_NUM_VRB: num_vrb_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // front: accept and classify
   assign busy = q_status.full;
   assign push = start && !busy;

   rivac_front #(
      .RIV_WIDTH(RIV_WIDTH)
   ) u_front (
      .req_mode      (req_mode),
      .req_length_rbs(req_length_rbs),
      .req_start_rb  (req_start_rb),
      .req_riv_in    (req_riv_in),
      .num_prb       (num_prb_ff),
      .item          (front_item)
   );

   rivac_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(front_item),
      .pop      (q_status.nonempty),
      .head_item(head_item),
      .status   (q_status)
   );

   // back: multiply / divide pipeline, drains one beat per cycle
   rivac_back #(
      .RIV_WIDTH(RIV_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .item_valid(q_status.nonempty),
      .item      (head_item),
      .num_prb   (num_prb_ff),
      .num_vrb   (num_vrb_ff),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_riv_out    = rsp.riv_out;
   assign rsp_length_out = rsp.length_out;
   assign rsp_start_out  = rsp.start_out;

endmodule

>>> rtl/rivac_front.sv
`timescale 1ns / 1ps

module rivac_front #(
   parameter int RIV_WIDTH = 13
) (
   input  logic                           req_mode,
   input  logic [rivac_pkg::NPRB_W-1:0]   req_length_rbs,
   input  logic [rivac_pkg::NPRB_W-1:0]   req_start_rb,
   input  logic [rivac_pkg::RIV_IN_W-1:0] req_riv_in,
   input  logic [rivac_pkg::NPRB_W-1:0]   num_prb,
   output rivac_pkg::item_type            item
);

   localparam int RW = (RIV_WIDTH < rivac_pkg::RIV_IN_W) ? RIV_WIDTH : rivac_pkg::RIV_IN_W;
   localparam logic [rivac_pkg::RIV_IN_W-1:0] RIV_MASK =
      rivac_pkg::RIV_IN_W'((32'd1 << RW) - 32'd1);

   logic [rivac_pkg::NPRB_W-1:0]    len_m1;
   logic                            short_alloc;
   logic [rivac_pkg::RIV_OUT_W-1:0] n_ext;

   // pick the encode branch: zero length wraps and takes the long form
   always_comb begin
      len_m1      = req_length_rbs - 7'd1;
      short_alloc = (req_length_rbs != '0) && (len_m1 <= (num_prb >> 1));
      n_ext       = rivac_pkg::RIV_OUT_W'(num_prb);
   end

   // factor and addend so that the back end only does n * factor + addend
   always_comb begin
      item.mode = rivac_pkg::mode_type'(req_mode);
      if (short_alloc) begin
         item.factor = rivac_pkg::RIV_OUT_W'(len_m1);
         item.addend = rivac_pkg::RIV_OUT_W'(req_start_rb);
      end else begin
         item.factor = n_ext - rivac_pkg::RIV_OUT_W'(req_length_rbs) + 14'd1;
         item.addend = n_ext - 14'd1 - rivac_pkg::RIV_OUT_W'(req_start_rb);
      end
      item.riv = req_riv_in & RIV_MASK;
   end

endmodule

>>> rtl/rivac_queue.sv
`timescale 1ns / 1ps
`include "riv_allocation_codec_core_assert.svh"

module rivac_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rivac_pkg::item_type     push_item,
   input  logic                    pop,
   output rivac_pkg::item_type     head_item,
   output rivac_pkg::q_status_type status
);

   rivac_pkg::item_type                 entries_ff [rivac_pkg::QUEUE_DEPTH];
   logic [rivac_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [rivac_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [rivac_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + rivac_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + rivac_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + rivac_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - rivac_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item       = entries_ff[rd_ptr_ff];
   assign status.full     = (count_ff == rivac_pkg::QUEUE_CNT_W'(rivac_pkg::QUEUE_DEPTH));
   assign status.nonempty = (count_ff != '0);

   `RIVAC_ASSERT_SAME(a_no_push_when_full, clock, reset, status.full, !push)
   `RIVAC_ASSERT_SAME(a_no_pop_when_empty, clock, reset, pop, status.nonempty)

endmodule

>>> rtl/rivac_back.sv
`timescale 1ns / 1ps
`include "riv_allocation_codec_core_assert.svh"

module rivac_back #(
   parameter int RIV_WIDTH = 13
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         item_valid,
   input  rivac_pkg::item_type          item,
   input  logic [rivac_pkg::NPRB_W-1:0] num_prb,
   input  logic [rivac_pkg::NPRB_W-1:0] num_vrb,
   output logic                         rsp_valid,
   output rivac_pkg::rsp_type           rsp
);

   localparam int RW = (RIV_WIDTH < rivac_pkg::RIV_IN_W) ? RIV_WIDTH : rivac_pkg::RIV_IN_W;
   localparam int CW = (RIV_WIDTH + 1 > rivac_pkg::RIV_IN_W) ? RIV_WIDTH + 1
                                                              : rivac_pkg::RIV_IN_W;

   rivac_pkg::stage_type stage_ff [RW+1];
   rivac_pkg::stage_type stage_in [RW+1];
   logic                 valid_ff [RW+1];

   // stage 0: take the queue head, form the encode product
   always_comb begin
      stage_in[0].mode   = item.mode;
      stage_in[0].prod   = rivac_pkg::RIV_OUT_W'(num_prb) * item.factor;
      stage_in[0].addend = item.addend;
      stage_in[0].riv    = item.riv;
      stage_in[0].quo    = '0;
      stage_in[0].rem    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff[0] <= stage_in[0];
   end

   // restoring divider by num_prb, one quotient bit per stage, msb first
   for (genvar i = 1; i <= RW; i++) begin : g_div
      logic [rivac_pkg::NPRB_W:0] shifted;
      logic [rivac_pkg::NPRB_W:0] diff;
      logic                       take;

      always_comb begin
         shifted  = {stage_ff[i-1].rem, stage_ff[i-1].riv[RW-i]};
         diff     = shifted - {1'b0, num_prb};
         take     = (shifted >= {1'b0, num_prb});
         stage_in[i]     = stage_ff[i-1];
         stage_in[i].quo = {stage_ff[i-1].quo[rivac_pkg::RIV_IN_W-2:0], take};
         stage_in[i].rem = take ? diff[rivac_pkg::NPRB_W-1:0]
                                : shifted[rivac_pkg::NPRB_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         stage_ff[i] <= stage_in[i];
      end
   end

   // final step: encode sum, or decode with zero-divisor and fold handling
   rivac_pkg::stage_type                fin;
   logic                                n_zero;
   logic [RIV_WIDTH-1:0]                quot;
   logic [rivac_pkg::RIV_IN_W-1:0]      remd;
   logic [RIV_WIDTH:0]                  dlen;
   logic [rivac_pkg::RIV_IN_W-1:0]      vrb_ext;
   logic [rivac_pkg::RIV_IN_W-1:0]      room;
   logic                                fold;
   rivac_pkg::rsp_type                  rsp_in;
   rivac_pkg::rsp_type                  rsp_ff;
   logic                                rsp_valid_ff;

   always_comb begin
      fin     = stage_ff[RW];
      n_zero  = (num_prb == '0);
      quot    = n_zero ? '1 : RIV_WIDTH'(fin.quo);
      remd    = n_zero ? fin.riv : rivac_pkg::RIV_IN_W'(fin.rem);
      dlen    = (RIV_WIDTH+1)'(quot) + (RIV_WIDTH+1)'(1);
      vrb_ext = rivac_pkg::RIV_IN_W'(num_vrb);
      room    = vrb_ext - remd;
      // a start above the virtual count wraps the room and never folds
      fold    = (remd <= vrb_ext) && (CW'(dlen) > CW'(room));

      rsp_in = '0;
      unique case (fin.mode)
         rivac_pkg::MODE_ENCODE: begin
            rsp_in.riv_out = fin.prod + fin.addend;
         end
         rivac_pkg::MODE_DECODE: begin
            if (fold) begin
               rsp_in.length_out = 8'(num_prb) - 8'(quot) + 8'd1;
               rsp_in.start_out  = 8'(num_prb) - 8'(remd) - 8'd1;
            end else begin
               rsp_in.length_out = 8'(dlen);
               rsp_in.start_out  = 8'(remd);
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff[RW];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `RIVAC_ASSERT_LATER(a_beat_latency, clock, reset, item_valid, RW + 2, rsp_valid_ff)
   `RIVAC_ASSERT_SAME(a_rem_below_n, clock, reset, valid_ff[RW] && !n_zero, fin.rem < num_prb)

endmodule
